### sv/wgc_pkg.sv
`default_nettype none
package wgc_pkg;

  localparam int QUAL_W     = 2;
  localparam int WIRE_W     = 7;
  localparam int TBIN_W     = 5;
  localparam int GWIN_W     = 3;
  localparam int ROWS_W     = 4;
  localparam int CFG_DATA_W = 3;

  typedef logic [QUAL_W-1:0]  qual_t;
  typedef logic [WIRE_W-1:0]  wire_t;
  typedef logic [TBIN_W-1:0]  tbin_t;
  typedef logic [GWIN_W-1:0]  gwin_t;
  typedef logic [ROWS_W-1:0]  rows_t;
  typedef logic [0:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_GHOST_WINDOW  = 1'b0;
  localparam cfg_idx_t CFG_GHOST_COMPARE = 1'b1;

  // same-row neighbour view of one wire under decision
  typedef struct packed {
    qual_t q;
    qual_t ql;
    logic  has_right;
    qual_t qr;
  } wgc_nbr_t;

endpackage
`default_nettype wire

### sv/wgc_decide.sv
`default_nettype none
module wgc_decide #(
  parameter int HIST_ROWS = 4
) (
  input  wgc_pkg::wgc_nbr_t       nbr,
  input  logic [2*HIST_ROWS-1:0]  left_hist,
  input  logic [2*HIST_ROWS-1:0]  right_hist,
  input  wgc_pkg::rows_t          rows,
  input  logic                    cmp_better,
  output logic                    keep
);
  import wgc_pkg::*;

  logic  hit_l;
  logic  hit_r;
  qual_t old_l;
  qual_t old_r;

  // age k+1 sits in bits 2k+1:2k
  always_comb begin
    hit_l = 1'b0;
    hit_r = 1'b0;
    old_l = '0;
    old_r = '0;
    for (int k = 0; k < HIST_ROWS; k++) begin
      old_l = left_hist[2*k +: 2];
      old_r = right_hist[2*k +: 2];
      if (ROWS_W'(k) < rows) begin
        if (old_l != '0 && (!cmp_better || old_l > nbr.q)) hit_l = 1'b1;
        if (old_r != '0 && (!cmp_better || old_r > nbr.q)) hit_r = 1'b1;
      end
    end
  end

  assign keep = (nbr.q != '0)
             && !(nbr.has_right && nbr.qr > nbr.q)
             && !(nbr.ql != '0 && nbr.ql >= nbr.q)
             && !hit_l
             && !(nbr.has_right && hit_r);

endmodule
`default_nettype wire

### sv/wire_ghost_cancel.sv
// Ghost cancellation for wire-group candidates.
// Input channel (in_*): one candidate per transfer, wires in raster order
// along a time-bin row; in_row_last marks the row end. Result channel
// (out_*): one keep/cancel decision per transfer. A wire is decided when
// its right neighbour arrives; the last wire of a row is decided right
// after the wire before it, so a row-end transfer can yield two results.
// Config port (cfg_*): ghost_window at index 0, ghost_compare at index 1;
// the user must see that it is written only while the block is idle, as
// the block does not enforce this. Throughput: one input transfer per
// cycle while in_stall is low; a row end that closes a held wire gives its
// two results one after the other, set by the single output register and
// the one write port of the history memory. A decision goes from the work
// stage to the output register; a row end's second one waits in p_* first.
// Reset (synchronous, rst_n low) empties the pipeline, marks all wire
// histories as empty through per-wire valid bits (no clearing pass) and
// loads ghost_window=1, ghost_compare=0.
// A stall on out_stall holds the output register; the stage behind it
// keeps its item and in_stall rises once it cannot move.
`default_nettype none
module wire_ghost_cancel #(
  parameter int MAX_WIRES      = 128,
  parameter int MAX_GHOST_ROWS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wgc_pkg::qual_t     in_quality,
  input  wgc_pkg::wire_t     in_wire_req,
  input  wgc_pkg::tbin_t     in_time_bin,
  input  logic               in_row_last,
  output logic               out_valid,
  input  logic               out_stall,
  output wgc_pkg::wire_t     out_wire,
  output logic               out_keep,
  output logic               out_row_done,
  input  logic               cfg_we,
  input  wgc_pkg::cfg_idx_t  cfg_index,
  input  wgc_pkg::cfg_data_t cfg_wdata
);
  import wgc_pkg::*;

  localparam int AW = $clog2(MAX_WIRES);
  localparam int HW = 2 * MAX_GHOST_ROWS;

  typedef logic [HW-1:0] hist_t;
  typedef logic [AW-1:0] idx_t;

  function automatic hist_t push(input hist_t h, input qual_t q);
    return (h << 2) | hist_t'(q);
  endfunction

  // configuration
  gwin_t gw_r;
  logic  cmp_r;

  // work stage
  logic  s_vld_r;
  qual_t s_q_r;
  wire_t s_w_r;
  tbin_t s_tb_r;
  logic  s_last_r;
  logic  s_inr_r;
  hist_t s_rd_r;
  logic  s_rdv_r;
  logic  s_byp_r;
  hist_t s_bypd_r;

  // wire waiting for its right neighbour, and the one left of it
  logic  hold_vld_r;
  qual_t hold_q_r;
  wire_t hold_w_r;
  logic  hold_inr_r;
  hist_t hold_hist_r;
  qual_t left_q_r;
  hist_t left_hist_r;

  // second result of a row end
  logic  p_vld_r;
  wire_t p_wire_r;
  logic  p_keep_r;
  logic  p_wen_r;
  idx_t  p_idx_r;
  hist_t p_wdata_r;

  logic  out_vld_r;
  wire_t out_wire_r;
  logic  out_keep_r;
  logic  out_done_r;

  hist_t              hist_mem [MAX_WIRES];
  logic [MAX_WIRES-1:0] vbit_r;

  logic [7:0] in_ext;
  logic [7:0] s_ext;
  logic [7:0] hold_ext;
  logic       in_inr;
  idx_t       in_idx;
  idx_t       s_idx;
  idx_t       hold_idx;
  hist_t      cur_hist;
  hist_t      held_push;
  hist_t      dual_push;
  hist_t      cur_push;
  logic       same;
  logic [4:0] rows5;
  rows_t      rows;
  wgc_nbr_t   nbr_held;
  wgc_nbr_t   nbr_last;
  hist_t      last_lhist;
  logic       keep_held;
  logic       keep_last;
  logic       no_res;
  logic       out_free;
  logic       p_go;
  logic       s_go;
  logic       mk_pend;
  logic       in_rdy;
  logic       in_acc;
  logic       wen;
  idx_t       widx;
  hist_t      wdata;

  assign in_ext   = {1'b0, in_wire_req};
  assign s_ext    = {1'b0, s_w_r};
  assign hold_ext = {1'b0, hold_w_r};
  assign in_inr   = {1'b0, in_ext} < 9'(MAX_WIRES);
  assign in_idx   = in_ext[AW-1:0];
  assign s_idx    = s_ext[AW-1:0];
  assign hold_idx = hold_ext[AW-1:0];

  assign cur_hist = !s_inr_r ? '0 :
                    s_byp_r  ? s_bypd_r :
                    s_rdv_r  ? s_rd_r : '0;

  assign same      = hold_vld_r && s_inr_r && (s_w_r == hold_w_r);
  assign held_push = push(hold_hist_r, hold_q_r);
  assign dual_push = push(held_push, s_q_r);
  assign cur_push  = push(cur_hist, s_q_r);

  // rows searched: min(ghost_window, MAX_GHOST_ROWS, time_bin)
  always_comb begin
    rows5 = 5'(gw_r);
    if (rows5 > 5'(MAX_GHOST_ROWS)) rows5 = 5'(MAX_GHOST_ROWS);
    if (rows5 > s_tb_r) rows5 = s_tb_r;
    rows = rows5[ROWS_W-1:0];
  end

  assign nbr_held   = '{q: hold_q_r, ql: left_q_r, has_right: 1'b1, qr: s_q_r};
  assign nbr_last   = '{q: s_q_r, ql: (hold_vld_r ? hold_q_r : '0),
                        has_right: 1'b0, qr: '0};
  assign last_lhist = hold_vld_r ? hold_hist_r : '0;

  wgc_decide #(.HIST_ROWS(MAX_GHOST_ROWS)) u_dec_held (
    .nbr        (nbr_held),
    .left_hist  (left_hist_r),
    .right_hist (cur_hist),
    .rows       (rows),
    .cmp_better (cmp_r),
    .keep       (keep_held)
  );

  wgc_decide #(.HIST_ROWS(MAX_GHOST_ROWS)) u_dec_last (
    .nbr        (nbr_last),
    .left_hist  (last_lhist),
    .right_hist ('0),
    .rows       (rows),
    .cmp_better (cmp_r),
    .keep       (keep_last)
  );

  // flow control
  assign no_res   = !hold_vld_r && !s_last_r;
  assign out_free = !out_vld_r || !out_stall;
  assign p_go     = p_vld_r && out_free;
  assign s_go     = s_vld_r && !p_vld_r && (out_free || no_res);
  assign mk_pend  = s_go && hold_vld_r && s_last_r;
  assign in_rdy   = p_vld_r ? p_go : (!s_vld_r || (s_go && !mk_pend));
  assign in_acc   = in_valid && in_rdy;
  assign in_stall = !in_rdy;

  // history write port
  always_comb begin
    wen   = 1'b0;
    widx  = s_idx;
    wdata = cur_push;
    priority if (p_go) begin
      wen   = p_wen_r;
      widx  = p_idx_r;
      wdata = p_wdata_r;
    end else if (s_go && hold_vld_r) begin
      wen   = hold_inr_r;
      widx  = hold_idx;
      wdata = (s_last_r && same) ? dual_push : held_push;
    end else if (s_go && s_last_r) begin
      wen   = s_inr_r;
      widx  = s_idx;
      wdata = cur_push;
    end else begin
      wen   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) hist_mem[widx] <= wdata;
    if (in_acc) s_rd_r <= hist_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbit_r <= '0;
    end else if (wen) begin
      vbit_r[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r  <= GWIN_W'(1);
      cmp_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GHOST_WINDOW:  gw_r  <= cfg_wdata[GWIN_W-1:0];
        CFG_GHOST_COMPARE: cmp_r <= cfg_wdata[0];
      endcase
    end
  end

  // stage capture; same-edge memory write is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_acc) begin
      s_vld_r <= 1'b1;
    end else if (s_go) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_q_r    <= in_quality;
      s_w_r    <= in_wire_req;
      s_tb_r   <= in_time_bin;
      s_last_r <= in_row_last;
      s_inr_r  <= in_inr;
      s_rdv_r  <= vbit_r[in_idx];
      s_byp_r  <= wen && (widx == in_idx);
      s_bypd_r <= wdata;
    end
  end

  // held wire and left neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r  <= 1'b0;
      left_q_r    <= '0;
      left_hist_r <= '0;
    end else if (s_go) begin
      if (s_last_r) begin
        hold_vld_r  <= 1'b0;
        left_q_r    <= '0;
        left_hist_r <= '0;
      end else begin
        hold_vld_r  <= 1'b1;
        left_q_r    <= hold_vld_r ? hold_q_r : '0;
        left_hist_r <= hold_vld_r ? hold_hist_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && !s_last_r) begin
      hold_q_r    <= s_q_r;
      hold_w_r    <= s_w_r;
      hold_inr_r  <= s_inr_r;
      hold_hist_r <= same ? held_push : cur_hist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (mk_pend) begin
      p_vld_r <= 1'b1;
    end else if (p_go) begin
      p_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mk_pend) begin
      p_wire_r  <= s_w_r;
      p_keep_r  <= keep_last;
      p_wen_r   <= s_inr_r && !same;
      p_idx_r   <= s_idx;
      p_wdata_r <= cur_push;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (p_go || (s_go && !no_res)) begin
      out_vld_r <= 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go) begin
      out_wire_r <= p_wire_r;
      out_keep_r <= p_keep_r;
      out_done_r <= 1'b1;
    end else if (s_go && !no_res) begin
      out_wire_r <= hold_vld_r ? hold_w_r : s_w_r;
      out_keep_r <= hold_vld_r ? keep_held : keep_last;
      out_done_r <= !hold_vld_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_wire     = out_wire_r;
  assign out_keep     = out_keep_r;
  assign out_row_done = out_done_r;

  // the second result of a row end only waits with the stage empty
  a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> !s_vld_r)
    else $error("pending result with stage occupied");

  // no new item may enter while the pending result is stuck
  a_pend_block: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r && !p_go |-> in_stall)
    else $error("input taken behind pending result");

  // row end with a held wire leaves the pending result and clears the hold
  a_pend_made: assert property (@(posedge clk) disable iff (!rst_n)
    mk_pend |=> p_vld_r && !hold_vld_r)
    else $error("row end did not stage its second result");

  // every accepted transfer lands in the stage
  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s_vld_r)
    else $error("accepted item lost");

endmodule
`default_nettype wire
